[rtl/core/press_level_event_qualifier_macros.svh]
// assertion helpers for the rtl of the press level event qualifier
`ifndef PRESS_LEVEL_EVENT_QUALIFIER_MACROS_SVH
`define PRESS_LEVEL_EVENT_QUALIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/plq_pkg.sv]
`timescale 1ns / 1ps

package plq_pkg;

  localparam int BUTTON_COUNT = 24;
  localparam int BUTTON_W     = 5;
  localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int LEVEL_W      = 2;
  localparam int THR_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [THR_W-1:0] WEAK_RESET   = 16'd10;
  localparam logic [THR_W-1:0] NORMAL_RESET = 16'd20;
  localparam logic [THR_W-1:0] STRONG_RESET = 16'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEAK   = 2'd0,
    REG_NORMAL = 2'd1,
    REG_STRONG = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_STRONGER = 2'd1,
    KIND_RELEASE  = 2'd2
  } event_kind_t;

  localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_WEAK   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_STRONG = 2'd3;

  // one entry of the per-button state
  typedef struct packed {
    logic [LEVEL_W-1:0] prev_level;
    logic [LEVEL_W-1:0] held;
  } plq_entry_t;

  // write-back request from the decision stage
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    plq_entry_t       data;
  } plq_wr_t;

endpackage

[rtl/core/plq_state.sv]
`timescale 1ns / 1ps

module plq_state import plq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  plq_wr_t          wr,
  output plq_entry_t       rd_data
);

  plq_entry_t              mem [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] valid_r;
  plq_entry_t              rd_data_r;
  logic                    rd_valid_r;
  logic                    byp_r;
  plq_entry_t              byp_data_r;

  // storage array, read data registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      byp_data_r <= wr.data;
    end
  end

  // entry valid bits stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
        // write landing on the same entry in the read cycle is forwarded
        byp_r      <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_data = byp_data_r;
    end else if (rd_valid_r) begin
      rd_data = rd_data_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

[rtl/core/press_level_event_qualifier.sv]
// press level event qualifier: grades each sample against three thresholds
// and qualifies press start, stronger and release events per button
// path: input item registered in the decision stage, then in the output register
// throughput: one item per cycle unless output stalls, set by state ram read-modify-write
// reset: thresholds return to 10/20/30, all button state reads as zero
`timescale 1ns / 1ps
`include "press_level_event_qualifier_macros.svh"

module press_level_event_qualifier import plq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // button[4:0], sample[20:5], baseline[36:21], pad
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // event_button[4:0], strength[6:5], pad
  output logic [1:0]           out_tuser,  // event_kind[1:0]
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // threshold registers
  logic [THR_W-1:0] weak_thr_r, normal_thr_r, strong_thr_r;

  // input unpacking
  logic [BUTTON_W-1:0] in_button;
  logic [THR_W-1:0]    in_sample;
  logic [THR_W-1:0]    in_baseline;
  logic                in_accept;
  logic                in_range;
  logic signed [THR_W:0] diff;
  logic [LEVEL_W-1:0]  level;

  // decision stage
  logic                s1_valid_r;
  logic                s1_range_r;
  logic [BUTTON_W-1:0] s1_button_r;
  logic [LEVEL_W-1:0]  s1_level_r;
  logic                s1_adv;
  plq_entry_t          cur;
  plq_wr_t             wr;
  logic [LEVEL_W-1:0]  held_nxt;
  logic                emit;
  event_kind_t         kind;
  logic [LEVEL_W-1:0]  str;

  // output register
  logic                out_valid_r;
  logic [BUTTON_W-1:0] out_button_r;
  event_kind_t         out_kind_r;
  logic [LEVEL_W-1:0]  out_str_r;

  // config port always ready, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weak_thr_r   <= WEAK_RESET;
      normal_thr_r <= NORMAL_RESET;
      strong_thr_r <= STRONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WEAK:   weak_thr_r   <= cfg_data;
        REG_NORMAL: normal_thr_r <= cfg_data;
        REG_STRONG: strong_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_button   = in_tdata[BUTTON_W-1:0];
  assign in_sample   = in_tdata[BUTTON_W +: THR_W];
  assign in_baseline = in_tdata[BUTTON_W+THR_W +: THR_W];
  assign in_accept   = in_tvalid && in_tready;
  assign in_range    = ({1'b0, in_button} < (BUTTON_W+1)'(BUTTON_COUNT));

  // signed difference at full width, then graded strongest first
  assign diff = $signed({1'b0, in_sample}) - $signed({1'b0, in_baseline});

  always_comb begin
    if (diff >= $signed({1'b0, strong_thr_r})) begin
      level = LEVEL_STRONG;
    end else if (diff >= $signed({1'b0, normal_thr_r})) begin
      level = LEVEL_NORMAL;
    end else if (diff >= $signed({1'b0, weak_thr_r})) begin
      level = LEVEL_WEAK;
    end else begin
      level = LEVEL_NONE;
    end
  end

  // decision stage moves on unless a result is stuck in the output register
  assign s1_adv    = s1_valid_r && !(out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_range_r  <= in_range;
      s1_button_r <= in_button;
      s1_level_r  <= level;
    end
  end

  // per-button state ram; out of range buttons read entry zero and never write
  plq_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_range ? in_button[IDX_W-1:0] : '0),
    .wr      (wr),
    .rd_data (cur)
  );

  // event rules on level, previous level and held strength
  always_comb begin
    held_nxt = cur.held;
    emit     = 1'b0;
    kind     = KIND_START;
    str      = s1_level_r;
    if (cur.held == LEVEL_NONE) begin
      if (s1_level_r != LEVEL_NONE && cur.prev_level != LEVEL_NONE) begin
        held_nxt = s1_level_r;
        emit     = 1'b1;
      end
    end else if (s1_level_r > cur.held) begin
      if (cur.prev_level == s1_level_r) begin
        held_nxt = s1_level_r;
        kind     = KIND_STRONGER;
        emit     = 1'b1;
      end
    end else if (s1_level_r == LEVEL_NONE) begin
      if (cur.prev_level == LEVEL_NONE) begin
        held_nxt = LEVEL_NONE;
        kind     = KIND_RELEASE;
        str      = cur.held;
        emit     = 1'b1;
      end
    end
  end

  // write back in the cycle the stage hands off
  assign wr.en              = s1_adv && s1_range_r;
  assign wr.addr            = s1_button_r[IDX_W-1:0];
  assign wr.data.prev_level = s1_level_r;
  assign wr.data.held       = held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_range_r && emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_button_r <= s1_button_r;
      out_kind_r   <= kind;
      out_str_r    <= str;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_str_r, out_button_r};
  assign out_tuser  = out_kind_r;

  // a stuck result must block new input while the stage is full
  `PLQ_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_tready && s1_valid_r, !in_tready, "input taken while output stalled")
  // state is only written when the stage hands off an in-range item
  `PLQ_ASSERT_NOW(a_write_on_advance, wr.en, s1_valid_r && s1_range_r, "state write without a live item")
  // every reported strength is a real press level
  `PLQ_ASSERT_NOW(a_strength_nonzero, out_valid_r, out_str_r != LEVEL_NONE, "event with zero strength")
  // an out of range button never produces a result
  `PLQ_ASSERT_NEXT(a_range_silent, s1_adv && !s1_range_r, !out_valid_r, "event for unknown button")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import plq_pkg::*;

  localparam int IDLE_PCT        = 28;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int PHASE_COUNT     = 7;
  localparam int HOLD_CYCLES     = 80;
  // margin after the last expected result has come out
  localparam int SETTLE_CYCLES   = 4;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  // the two-bit index has one code that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [BUTTON_W-1:0] button;
    event_kind_t         kind;
    logic [LEVEL_W-1:0]  strength;
  } press_event_t;

  // one row of the opening sequence; typed rows carry their own expectation
  typedef struct {
    logic [BUTTON_W-1:0] button;
    logic [THR_W-1:0]    sample;
    logic [THR_W-1:0]    baseline;
    bit                  typed;
    bit                  fires;
    event_kind_t         kind;
    logic [LEVEL_W-1:0]  strength;
  } sample_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata   = '0;  // button[4:0], sample[20:5], baseline[36:21], pad
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;        // event_button[4:0], strength[6:5], pad
  logic [1:0]           out_tuser;        // event_kind[1:0]
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [THR_W-1:0]     cfg_data   = '0;

  press_level_event_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------
  // shadow of the block: thresholds and per-button state
  // ---------------------------------------------------------------
  logic [THR_W-1:0]   weak_thr   = WEAK_RESET;
  logic [THR_W-1:0]   normal_thr = NORMAL_RESET;
  logic [THR_W-1:0]   strong_thr = STRONG_RESET;
  logic [LEVEL_W-1:0] prior_level [BUTTON_COUNT] = '{default: '0};
  logic [LEVEL_W-1:0] held_level  [BUTTON_COUNT] = '{default: '0};

  press_event_t events_due [$];
  int           mismatches = 0;

  // full-width signed difference, strongest threshold checked first
  function automatic logic [LEVEL_W-1:0] grade_level(input logic [THR_W-1:0] smp,
                                                     input logic [THR_W-1:0] bas);
    int gap;
    gap = int'(smp) - int'(bas);
    if (gap >= int'(strong_thr)) return LEVEL_STRONG;
    if (gap >= int'(normal_thr)) return LEVEL_NORMAL;
    if (gap >= int'(weak_thr))   return LEVEL_WEAK;
    return LEVEL_NONE;
  endfunction

  // advances the shadow state by one sample; returns 1 when an event is due
  function automatic bit qualify_sample(input logic [BUTTON_W-1:0] btn,
                                        input logic [THR_W-1:0] smp,
                                        input logic [THR_W-1:0] bas,
                                        output press_event_t ev);
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] prev;
    logic [LEVEL_W-1:0] held;
    bit                 fired;
    fired = 1'b0;
    ev = '{btn, KIND_START, LEVEL_NONE};
    // buttons past the end are dropped without touching state
    if (btn >= BUTTON_COUNT) return 1'b0;
    lvl  = grade_level(smp, bas);
    prev = prior_level[btn];
    held = held_level[btn];
    if (held == LEVEL_NONE) begin
      // idle: two nonzero levels in a row start a press
      if (lvl != LEVEL_NONE && prev != LEVEL_NONE) begin
        held_level[btn] = lvl;
        ev.kind = KIND_START;
        ev.strength = lvl;
        fired = 1'b1;
      end
    end else if (lvl > held) begin
      // rising: needs the same level twice
      if (prev == lvl) begin
        held_level[btn] = lvl;
        ev.kind = KIND_STRONGER;
        ev.strength = lvl;
        fired = 1'b1;
      end
    end else if (lvl == LEVEL_NONE) begin
      // two zero levels release with the held strength
      if (prev == LEVEL_NONE) begin
        ev.kind = KIND_RELEASE;
        ev.strength = held;
        held_level[btn] = LEVEL_NONE;
        fired = 1'b1;
      end
    end
    prior_level[btn] = lvl;
    return fired;
  endfunction

  // ---------------------------------------------------------------
  // result side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------
  bit calm         = 1'b0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      // long hold-off so the block backs up into its input
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare every result item against the oldest expectation
  always @(posedge clk) begin : watch_results
    press_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (events_due.size() == 0) begin
        $error("unexpected item: event_button %0d event_kind %0d strength %0d",
               out_tdata[4:0], out_tuser, out_tdata[6:5]);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        if (out_tdata[4:0] !== want.button) begin
          $error("event_button: expected %0d, got %0d", want.button, out_tdata[4:0]);
          mismatches++;
        end
        if (out_tuser !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata[6:5] !== want.strength) begin
          $error("strength: expected %0d, got %0d", want.strength, out_tdata[6:5]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------

  // random idle cycles, then hold the item until it is taken
  task automatic offer_sample(input logic [BUTTON_W-1:0] btn,
                              input logic [THR_W-1:0] smp,
                              input logic [THR_W-1:0] bas);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, bas, smp, btn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and let every expected item come out, then let the pipe settle
  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WEAK:   weak_thr   = val;
      REG_NORMAL: normal_thr = val;
      REG_STRONG: strong_thr = val;
      default: ;  // unused index, no register changes
    endcase
  endtask

  // opening sequence at the reset thresholds 10 / 20 / 30
  sample_row_t opening_rows [23] = '{
    // first sample after reset, previous level still zero
    '{5'd0,  16'd100,   16'd90,    1'b1, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd0,  16'd100,   16'd90,    1'b1, 1'b1, KIND_START,    LEVEL_WEAK},
    '{5'd0,  16'd130,   16'd100,   1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd0,  16'd130,   16'd100,   1'b1, 1'b1, KIND_STRONGER, LEVEL_STRONG},
    // sample below its baseline grades as zero
    '{5'd0,  16'd0,     16'd65535, 1'b1, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd0,  16'd0,     16'd0,     1'b1, 1'b1, KIND_RELEASE,  LEVEL_STRONG},
    // highest button at the widest difference
    '{5'd23, 16'd65535, 16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd23, 16'd65535, 16'd0,     1'b1, 1'b1, KIND_START,    LEVEL_STRONG},
    '{5'd23, 16'd65535, 16'd0,     1'b1, 1'b0, KIND_START,    LEVEL_NONE},
    // button indexes past the end are ignored
    '{5'd24, 16'd65535, 16'd0,     1'b1, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd31, 16'd65535, 16'd65535, 1'b1, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd23, 16'd0,     16'd1,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd23, 16'd0,     16'd1,     1'b1, 1'b1, KIND_RELEASE,  LEVEL_STRONG},
    // start at a lower level than the one before, then climb and drop back
    '{5'd5,  16'd20,    16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd15,    16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd20,    16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd25,    16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd0,     16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd12,    16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd0,     16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd5,  16'd0,     16'd0,     1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    // alternating bit patterns on sample and baseline
    '{5'd16, 16'h5555,  16'h0000,  1'b0, 1'b0, KIND_START,    LEVEL_NONE},
    '{5'd16, 16'hAAAA,  16'h2AAA,  1'b0, 1'b0, KIND_START,    LEVEL_NONE}
  };

  initial begin : stimulus
    press_event_t        ev;
    logic [BUTTON_W-1:0] btn;
    logic [THR_W-1:0]    smp;
    logic [THR_W-1:0]    bas;
    logic [THR_W-1:0]    w_thr;
    logic [THR_W-1:0]    n_thr;
    logic [THR_W-1:0]    s_thr;
    int                  gap;
    int                  reps;
    int                  phase_items;
    bit                  steady;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; typed rows push their own expectation
    foreach (opening_rows[i]) begin
      offer_sample(opening_rows[i].button, opening_rows[i].sample, opening_rows[i].baseline);
      if (qualify_sample(opening_rows[i].button, opening_rows[i].sample,
                         opening_rows[i].baseline, ev) && !opening_rows[i].typed)
        events_due.push_back(ev);
      if (opening_rows[i].typed && opening_rows[i].fires)
        events_due.push_back('{opening_rows[i].button, opening_rows[i].kind,
                               opening_rows[i].strength});
    end
    drain_results();

    for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
      case (phase)
        1: begin w_thr = 16'd10;    n_thr = 16'd20;    s_thr = 16'd30;    end
        2: begin w_thr = 16'd0;     n_thr = 16'd0;     s_thr = 16'd0;     end
        3: begin w_thr = 16'd65535; n_thr = 16'd65535; s_thr = 16'd65535; end
        // thresholds out of order: the first one met decides
        4: begin w_thr = 16'd30;    n_thr = 16'd20;    s_thr = 16'd10;    end
        5: begin w_thr = 16'd0;     n_thr = 16'd32768; s_thr = 16'd65535; end
        6: begin
          w_thr = 16'($urandom_range(200));
          n_thr = w_thr + 16'($urandom_range(2000));
          s_thr = n_thr + 16'($urandom_range(30000));
        end
        default: begin
          w_thr = 16'($urandom_range(65535));
          n_thr = 16'($urandom_range(65535));
          s_thr = 16'($urandom_range(65535));
        end
      endcase
      write_reg(REG_WEAK, w_thr);
      write_reg(REG_NORMAL, n_thr);
      write_reg(REG_STRONG, s_thr);
      // a write to the spare index must leave every threshold alone
      write_reg(REG_UNUSED, 16'($urandom_range(65535)));
      cfg_valid <= 1'b0;

      // one phase runs with no idling on either side
      calm = (phase == 2);
      if (phase == 4) holds_asked++;

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // mostly repeated levels on one button so events qualify, some noise
        btn = ($urandom_range(9) == 0) ? 5'($urandom_range(31, BUTTON_COUNT))
                                       : 5'($urandom_range(BUTTON_COUNT - 1));
        reps   = $urandom_range(3, 1);
        steady = $urandom_range(99) < 80;
        for (int r = 0; r < reps; r++) begin
          if (r == 0 || !steady) begin
            // aim the difference mostly at or just under a threshold, else below zero, zero, above strong or random
            case ($urandom_range(9))
              0:       gap = -int'($urandom_range(65535, 1));
              1:       gap = 0;
              2:       gap = int'(weak_thr);
              3:       gap = int'(weak_thr) - 1;
              4:       gap = int'(normal_thr);
              5:       gap = int'(normal_thr) - 1;
              6:       gap = int'(strong_thr);
              7:       gap = int'(strong_thr) - 1;
              8:       gap = int'(strong_thr) + int'($urandom_range(40));
              default: gap = int'($urandom_range(65535));
            endcase
            if (gap > 65535) gap = 65535;
          end
          // fresh baseline each time; in a steady run the difference stays put
          if (gap >= 0) begin
            bas = 16'($urandom_range(65535 - gap));
            smp = 16'(int'(bas) + gap);
          end else begin
            smp = 16'($urandom_range(65535 + gap));
            bas = 16'(int'(smp) - gap);
          end
          offer_sample(btn, smp, bas);
          if (qualify_sample(btn, smp, bas, ev)) events_due.push_back(ev);
          if (btn < BUTTON_COUNT) phase_items++;
        end
      end
      // sender waits for every outstanding item before the next setting
      drain_results();
    end

    calm = 1'b0;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/plq_pkg.sv
rtl/core/plq_state.sv
rtl/core/press_level_event_qualifier.sv
test/tb_top.sv
